>>> rtl/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked every clock outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> rtl/pgalloc_pkg.sv
// Shared constants and types of the page allocator
`default_nettype none
package pgalloc_pkg;
    localparam int PAGES_DEF = 32;
    localparam int PROCS_DEF = 16;
    localparam int ID_W = 10;
    localparam int SIZE_W = 11;
    localparam int PSZ_W = 7;
    localparam int FKB_W = 12;
    localparam logic [1:0] REQ_REG = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
        logic              sleeping;
        logic              evicted;
    } t_proc;
endpackage
`default_nettype wire

>>> rtl/pgalloc_mul.sv
// Shared multiplier: free page count times page size, saturated to the output width
`default_nettype none
module pgalloc_mul
    import pgalloc_pkg::*;
#(
    parameter int CNT_W = 6
) (
    input  wire logic [CNT_W-1:0] i_cnt,
    input  wire logic [PSZ_W-1:0] i_psz,
    output logic      [FKB_W-1:0] o_kb
);
    logic [CNT_W+PSZ_W-1:0] w_prod;
    assign w_prod = (CNT_W+PSZ_W)'(i_cnt) * (CNT_W+PSZ_W)'(i_psz);
    always_comb begin
        if (w_prod > (CNT_W+PSZ_W)'({FKB_W{1'b1}})) o_kb = {FKB_W{1'b1}};
        else o_kb = FKB_W'(w_prod);
    end
endmodule
`default_nettype wire

>>> rtl/page_allocator_with_sleep_eviction.sv
// Page allocator with eviction of sleeping processes (top level)
// Usage: pulse start with a request on i_req_type, i_owner_id, i_size_kb,
// i_sleeping and i_page_index while busy is low. The request is taken and
// busy rises; the result appears on the o_ ports with o_done, which is high
// for one cycle. Every request ends with a free page count over the whole
// page table. An allocate walks the page table one page per cycle: an
// initial count pass, then a check per process looked at plus a pass over
// the page table for each one evicted, then the first-fit pass and the
// final count. A new item may be taken in the cycle o_done is high.
// Page size is written with i_cfg_we and i_cfg_data; the user must write it
// only while idle, which the block itself does not enforce. 0 acts as 1.
// Reset clears the page table valid bits, process count and page pointer;
// process entries hold no reset value. The receiver cannot stall: o_done
// is high for a single cycle.
`default_nettype none
module page_allocator_with_sleep_eviction
    import pgalloc_pkg::*;
#(
    parameter int PAGES = PAGES_DEF,
    parameter int PROCS = PROCS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              i_cfg_we,
    input  wire logic [PSZ_W-1:0]  i_cfg_data,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [ID_W-1:0]   i_owner_id,
    input  wire logic [SIZE_W-1:0] i_size_kb,
    input  wire logic              i_sleeping,
    input  wire logic [4:0]        i_page_index,
    output logic                   o_done,
    output logic [1:0]             o_status,
    output logic [5:0]             o_pages_assigned,
    output logic [4:0]             o_processes_evicted,
    output logic [ID_W-1:0]        o_page_owner,
    output logic                   o_owner_valid,
    output logic [FKB_W-1:0]       o_free_kb
);
    localparam int PI_W = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int PC_W = $clog2(PAGES + 1);
    localparam int RI_W = (PROCS > 1) ? $clog2(PROCS) : 1;
    localparam int RC_W = $clog2(PROCS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_REG, S_RD, S_CNT, S_CHK, S_EVP, S_EVSCAN, S_FIT, S_FCNT, S_OUT
    } t_state;

    t_state r_state;
    logic [PAGES-1:0]  r_used;
    logic [ID_W-1:0]   r_owner [PAGES];
    t_proc             r_proc [PROCS];
    logic [RC_W-1:0]   r_pcount;
    logic [PC_W-1:0]   r_ptr;
    logic [PSZ_W-1:0]  r_psz;
    logic [1:0]        r_type;
    logic [ID_W-1:0]   r_id;
    logic [SIZE_W-1:0] r_size;
    logic [4:0]        r_idx;
    logic [PC_W-1:0]   r_pi;
    logic [RC_W-1:0]   r_ri;
    logic [PC_W-1:0]   r_free;
    logic [SIZE_W:0]   r_need;
    logic [PC_W-1:0]   r_asg;
    logic [RC_W-1:0]   r_ev;
    logic [ID_W-1:0]   r_evid;
    logic [1:0]        r_st;
    logic [ID_W-1:0]   r_rown;
    logic              r_rval;
    logic [FKB_W-1:0]  w_kb;
    logic [PSZ_W-1:0]  w_psz;
    logic [PI_W-1:0]   w_pi;
    t_proc             w_pr;

    assign w_psz = (r_psz == '0) ? PSZ_W'(1) : r_psz;
    assign w_pi = r_pi[PI_W-1:0];
    assign w_pr = r_proc[r_ri[RI_W-1:0]];
    assign busy = (r_state != S_IDLE);

    pgalloc_mul #(.CNT_W(PC_W)) u_mul (.i_cnt(r_free), .i_psz(w_psz), .o_kb(w_kb));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
            r_state <= S_IDLE;
            r_used <= '0;
            r_pcount <= '0;
            r_ptr <= '0;
            r_psz <= PSZ_W'(1);
        end else begin
            o_done <= (r_state == S_OUT);
            if (i_cfg_we) r_psz <= i_cfg_data;
            case (r_state)
                S_IDLE: if (start) begin
                    r_type <= i_req_type; r_id <= i_owner_id; r_size <= i_size_kb;
                    r_idx <= i_page_index; r_pi <= '0; r_ri <= '0; r_free <= '0;
                    r_asg <= '0; r_ev <= '0; r_rown <= '0; r_rval <= 1'b0;
                    r_st <= (i_req_type == REQ_REG && r_pcount >= RC_W'(PROCS)) ?
                            ST_FULL : ST_OK;
                    r_need <= '0;
                    case (i_req_type)
                        REQ_REG: begin
                            if (r_pcount >= RC_W'(PROCS)) begin
                                r_state <= S_FCNT;
                            end else begin
                                r_proc[r_pcount[RI_W-1:0]] <= '{i_owner_id, i_size_kb,
                                                               i_sleeping, 1'b0};
                                r_pcount <= r_pcount + 1'b1;
                                r_state <= S_REG;
                            end
                        end
                        REQ_ALLOC: r_state <= S_CNT;
                        REQ_READ:  r_state <= S_RD;
                        default:   r_state <= S_FCNT;
                    endcase
                end
                S_REG: begin
                    // ceil(size/psz) by repeated addition, one page per cycle
                    if (r_need < (SIZE_W+1)'(r_size) && r_ptr < PC_W'(PAGES)) begin
                        r_used[r_ptr[PI_W-1:0]] <= 1'b1;
                        r_owner[r_ptr[PI_W-1:0]] <= r_id;
                        r_ptr <= r_ptr + 1'b1;
                        r_asg <= r_asg + 1'b1;
                        r_need <= r_need + (SIZE_W+1)'(w_psz);
                    end else r_state <= S_FCNT;
                end
                S_RD: begin
                    if (32'(r_idx) < PAGES && r_used[PI_W'(r_idx)]) begin
                        r_rval <= 1'b1; r_rown <= r_owner[PI_W'(r_idx)];
                    end
                    r_state <= S_FCNT;
                end
                S_CNT: begin
                    if (!r_used[w_pi]) r_free <= r_free + 1'b1;
                    if (r_pi == PC_W'(PAGES-1)) r_state <= S_CHK;
                    else r_pi <= r_pi + 1'b1;
                end
                S_CHK: begin
                    // compare free KB against the request, pick next evictable
                    r_pi <= '0;
                    if ((FKB_W)'(r_size) <= w_kb) r_state <= S_FIT;
                    else if (r_ri >= r_pcount || r_ri >= RC_W'(PROCS)) begin
                        r_st <= ST_NOSPACE; r_state <= S_FCNT;
                    end else if (w_pr.sleeping && !w_pr.evicted && w_pr.size != '0) begin
                        r_evid <= w_pr.id;
                        r_proc[r_ri[RI_W-1:0]].evicted <= 1'b1;
                        if (r_ev != '1) r_ev <= r_ev + 1'b1;
                        r_state <= S_EVSCAN;
                    end else r_ri <= r_ri + 1'b1;
                end
                S_EVSCAN: begin
                    if (r_used[w_pi] && r_owner[w_pi] == r_evid) begin
                        r_used[w_pi] <= 1'b0; r_free <= r_free + 1'b1;
                    end
                    if (r_pi == PC_W'(PAGES-1)) begin
                        r_ri <= r_ri + 1'b1; r_state <= S_CHK;
                    end else r_pi <= r_pi + 1'b1;
                end
                S_FIT: begin
                    if (r_need < (SIZE_W+1)'(r_size) && r_pi < PC_W'(PAGES)) begin
                        if (!r_used[w_pi]) begin
                            r_used[w_pi] <= 1'b1; r_owner[w_pi] <= r_id;
                            r_asg <= r_asg + 1'b1;
                            r_need <= r_need + (SIZE_W+1)'(w_psz);
                        end
                        r_pi <= r_pi + 1'b1;
                    end else begin
                        r_pi <= '0; r_free <= '0; r_state <= S_EVP;
                    end
                end
                S_EVP, S_FCNT: begin
                    // final free page count, then show the result
                    if (r_state == S_FCNT) begin
                        r_pi <= '0; r_free <= '0; r_state <= S_EVP;
                    end else begin
                        if (!r_used[w_pi]) r_free <= r_free + 1'b1;
                        if (r_pi == PC_W'(PAGES-1)) r_state <= S_OUT;
                        else r_pi <= r_pi + 1'b1;
                    end
                end
                S_OUT: begin
                    o_status <= r_st;
                    o_pages_assigned <= 6'(r_asg);
                    o_processes_evicted <= (r_ev > RC_W'(31)) ? 5'd31 : 5'(r_ev);
                    o_page_owner <= r_rown;
                    o_owner_valid <= r_rval;
                    o_free_kb <= w_kb;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/pgalloc_checker.sv
// Port-level checker for the page allocator, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module pgalloc_checker
    import pgalloc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       o_done,
    input wire logic [1:0] o_status,
    input wire logic [5:0] o_pages_assigned,
    input wire logic [4:0] o_processes_evicted,
    input wire logic       o_owner_valid
);
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy, "busy did not rise")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, o_done, !busy, "busy with result")
    `ASSERT_IMPL(a_done_single, i_clk, i_rst_n, o_done, !$past(o_done), "double done")
    `ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, o_done && o_status == ST_NOSPACE,
        o_pages_assigned == 6'd0 && !o_owner_valid, "failed alloc assigned pages")
endmodule
bind page_allocator_with_sleep_eviction pgalloc_checker u_chk (.*);
`default_nettype wire
